// ===== rtl/lpfrd_pkg.sv =====
// Package for the length-prefixed file record deframer.
// Holds phase and result kind codes, widths and the structs shared by the modules.
// Depends on nothing.
package lpfrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned LimitW  = 64;
  localparam int unsigned AccW    = 24;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned AddrW   = 4;

  localparam logic [LimitW-1:0] SpaceLimitReset = 64'd1048576;

  localparam logic [PhaseW-1:0] PhModLen  = 3'd0;
  localparam logic [PhaseW-1:0] PhModStr  = 3'd1;
  localparam logic [PhaseW-1:0] PhPathLen = 3'd2;
  localparam logic [PhaseW-1:0] PhPathStr = 3'd3;
  localparam logic [PhaseW-1:0] PhSize    = 3'd4;
  localparam logic [PhaseW-1:0] PhContent = 3'd5;

  localparam logic [1:0] SizeLastIdx = 2'd3;

  localparam logic [KindW-1:0] KindMod     = 3'd0;
  localparam logic [KindW-1:0] KindPath    = 3'd1;
  localparam logic [KindW-1:0] KindContent = 3'd2;
  localparam logic [KindW-1:0] KindStart   = 3'd3;
  localparam logic [KindW-1:0] KindError   = 3'd4;

  localparam logic [0:0] RegSpaceLimit = 1'b0;

  typedef struct packed {
    logic              load;
    logic [LimitW-1:0] limit;
  } lpfrd_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    logic              last;
  } lpfrd_res_t;

endpackage

// ===== rtl/lpfrd_cfg.sv =====
// APB-style register block holding the space_limit register.
// Depends on lpfrd_pkg.
module lpfrd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpfrd_pkg::AddrW-1:0]  paddr,
  input  logic [lpfrd_pkg::LimitW-1:0] pwdata,
  output logic [lpfrd_pkg::LimitW-1:0] prdata,
  output logic                         pready,
  output lpfrd_pkg::lpfrd_cfg_t        cfg_o
);

  logic [lpfrd_pkg::LimitW-1:0] limit_q;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[3] == lpfrd_pkg::RegSpaceLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lpfrd_pkg::SpaceLimitReset;
    end else if (wr_en) begin
      limit_q <= pwdata;
    end
  end

  assign prdata      = (paddr[3] == lpfrd_pkg::RegSpaceLimit) ? limit_q : '0;
  assign cfg_o.load  = wr_en;
  assign cfg_o.limit = pwdata;

endmodule

// ===== rtl/lpfrd_parse.sv =====
// Record parser: phase, field counter, size accumulator, quota counter and error latch.
// Turns one accepted byte into at most one result. Depends on lpfrd_pkg.
module lpfrd_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpfrd_pkg::lpfrd_cfg_t       cfg_i,
  input  logic                        step_i,
  input  logic [lpfrd_pkg::ByteW-1:0] byte_i,
  output lpfrd_pkg::lpfrd_res_t       res_o
);

  logic [lpfrd_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [lpfrd_pkg::ValueW-1:0] remain_q, remain_d;
  logic [lpfrd_pkg::AccW-1:0]   acc_q, acc_d;
  logic [1:0]                   cnt_q, cnt_d;
  logic [lpfrd_pkg::LimitW-1:0] space_q, space_d;
  logic                         stuck_q, stuck_d;
  logic                         last_byte;
  logic [lpfrd_pkg::ValueW-1:0] size_full;
  logic [lpfrd_pkg::ValueW-1:0] byte_ext;

  assign last_byte = (remain_q <= 32'd1);
  assign size_full = {acc_q, byte_i};
  assign byte_ext  = {24'd0, byte_i};

  always_comb begin
    phase_d     = phase_q;
    remain_d    = remain_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    space_d     = space_q;
    stuck_d     = stuck_q;
    res_o.valid = 1'b0;
    res_o.kind  = lpfrd_pkg::KindMod;
    res_o.value = byte_ext;
    res_o.last  = 1'b0;
    if (step_i && !stuck_q) begin
      case (phase_q)
        lpfrd_pkg::PhModStr, lpfrd_pkg::PhPathStr: begin
          res_o.valid = 1'b1;
          res_o.kind  = (phase_q == lpfrd_pkg::PhModStr) ? lpfrd_pkg::KindMod
                                                          : lpfrd_pkg::KindPath;
          res_o.last  = last_byte;
          remain_d    = last_byte ? '0 : remain_q - 32'd1;
          if (last_byte) begin
            phase_d = (phase_q == lpfrd_pkg::PhModStr) ? lpfrd_pkg::PhPathLen
                                                        : lpfrd_pkg::PhSize;
          end
        end
        lpfrd_pkg::PhPathLen: begin
          remain_d = byte_ext;
          acc_d    = '0;
          cnt_d    = '0;
          phase_d  = (byte_i == '0) ? lpfrd_pkg::PhSize : lpfrd_pkg::PhPathStr;
        end
        lpfrd_pkg::PhSize: begin
          if (cnt_q != lpfrd_pkg::SizeLastIdx) begin
            acc_d = {acc_q[lpfrd_pkg::AccW-lpfrd_pkg::ByteW-1:0], byte_i};
            cnt_d = cnt_q + 2'd1;
          end else begin
            acc_d       = '0;
            cnt_d       = '0;
            res_o.valid = 1'b1;
            res_o.kind  = lpfrd_pkg::KindStart;
            res_o.value = size_full;
            res_o.last  = (size_full == '0);
            remain_d    = size_full;
            phase_d     = (size_full == '0) ? lpfrd_pkg::PhModLen : lpfrd_pkg::PhContent;
          end
        end
        lpfrd_pkg::PhContent: begin
          res_o.valid = 1'b1;
          if (space_q == '0) begin
            stuck_d     = 1'b1;
            res_o.kind  = lpfrd_pkg::KindError;
            res_o.value = '0;
          end else begin
            space_d    = space_q - 64'd1;
            res_o.kind = lpfrd_pkg::KindContent;
            res_o.last = last_byte;
            remain_d   = last_byte ? '0 : remain_q - 32'd1;
            if (last_byte) begin
              phase_d = lpfrd_pkg::PhModLen;
            end
          end
        end
        default: begin
          remain_d = byte_ext;
          phase_d  = (byte_i == '0) ? lpfrd_pkg::PhPathLen : lpfrd_pkg::PhModStr;
        end
      endcase
    end
    if (cfg_i.load) begin
      space_d = cfg_i.limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lpfrd_pkg::PhModLen;
      remain_q <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      space_q  <= lpfrd_pkg::SpaceLimitReset;
      stuck_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      space_q  <= space_d;
      stuck_q  <= stuck_d;
    end
  end

  // Once the quota error is raised, the parser stays frozen until reset.
  a_stuck_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |=> stuck_q)
    else $error("error latch cleared without reset");

  a_error_sets_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == lpfrd_pkg::KindError) |=> stuck_q)
    else $error("quota error given without latching");

  a_no_result_when_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |-> !res_o.valid)
    else $error("result produced while frozen");

  a_zero_size_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == lpfrd_pkg::KindStart && res_o.last && !cfg_i.load)
      |=> (phase_q == lpfrd_pkg::PhModLen))
    else $error("empty file did not return to the name length phase");

endmodule

// ===== rtl/length_prefixed_file_record_deframer.sv =====
// Channel   Dir  tdata / tuser / tlast
// s_axis    in   tdata[7:0] data_byte
// m_axis    out  tdata[31:0] value, tuser[2:0] kind, tlast last
// apb       in   space_limit at address 0, 64-bit data
// Each byte waits in the input register and is parsed in the cycle it leaves it.
// Results are registered for m_axis; one byte per cycle is sustained while m_axis is ready.
// Reset empties both registers and loads the quota from space_limit's reset value.
// A stall on m_axis holds the result; the input register then fills and s_axis_tready drops.
// Depends on lpfrd_pkg, lpfrd_cfg and lpfrd_parse.
module length_prefixed_file_record_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] value
  output logic [2:0]                    m_axis_tuser,   // [2:0] kind
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpfrd_pkg::AddrW-1:0]   paddr,
  input  logic [lpfrd_pkg::LimitW-1:0]  pwdata,
  output logic [lpfrd_pkg::LimitW-1:0]  prdata,
  output logic                          pready
);

  lpfrd_pkg::lpfrd_cfg_t        cfg;
  lpfrd_pkg::lpfrd_res_t        res;
  logic                         in_valid_q;
  logic [lpfrd_pkg::ByteW-1:0]  in_byte_q;
  logic                         out_valid_q;
  logic [lpfrd_pkg::KindW-1:0]  out_kind_q;
  logic [lpfrd_pkg::ValueW-1:0] out_value_q;
  logic                         out_last_q;
  logic                         consume;

  lpfrd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign consume       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || consume;

  lpfrd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (consume),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && res.valid) begin
      out_kind_q  <= res.kind;
      out_value_q <= res.value;
      out_last_q  <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
